>>> rtl/touch_point_to_screen_mapper_assert.svh
// Assertion macros for the mapper RTL.
// No dependencies; included by the top level only.
`ifndef TOUCH_POINT_TO_SCREEN_MAPPER_ASSERT_SVH
`define TOUCH_POINT_TO_SCREEN_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TPSM_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPSM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tpsm_pkg.sv
// Package of the touch point mapper: constants, register indexes and state types.
// No dependencies; used by the channel interfaces, the axis scaler and the top level.
package tpsm_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned RAW_BITS       = 2 * BYTE_BITS;
  localparam logic [BYTE_BITS-1:0] NIBBLE_MASK = 8'h0F;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LANDSCAPE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

  localparam int unsigned SCREEN_WIDTH_RST  = 320;
  localparam int unsigned SCREEN_HEIGHT_RST = 240;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_BUSY   = 3'b010,
    ST_FINISH = 3'b100
  } ctrl_state_t;

  typedef enum logic [3:0] {
    AX_IDLE  = 4'b0001,
    AX_MUL   = 4'b0010,
    AX_CHECK = 4'b0100,
    AX_DIV   = 4'b1000
  } axis_state_t;

endpackage

>>> rtl/tpsm_channels_if.sv
// Handshake channels of the touch point mapper: touch report in, display point out.
// Depends on tpsm_pkg for the default coordinate width.
interface tpsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] touch_count;
  logic [7:0] x_high;
  logic [7:0] x_low;
  logic [7:0] y_high;
  logic [7:0] y_low;

  modport source (output valid, touch_count, x_high, x_low, y_high, y_low, input ready);
  modport sink   (input valid, touch_count, x_high, x_low, y_high, y_low, output ready);
endinterface

interface tpsm_out_if #(parameter int unsigned CoordBits = tpsm_pkg::COORD_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] point_x;
  logic [CoordBits-1:0] point_y;
  logic                 pressed;

  modport source (output valid, point_x, point_y, pressed, input ready);
  modport sink   (input valid, point_x, point_y, pressed, output ready);
endinterface

>>> rtl/tpsm_axis_scale.sv
// One axis scaler: bit-serial multiply by (extent-1), bit-serial divide, clamp.
// Depends on tpsm_pkg; instantiated twice by the top level.
module tpsm_axis_scale #(
  parameter int unsigned CoordBits = tpsm_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CoordBits-1:0] value,
  input  logic [CoordBits-1:0] ext_m1,
  input  logic [CoordBits-1:0] denom,
  output logic                 busy,
  output logic [CoordBits-1:0] result
);
  import tpsm_pkg::*;

  localparam int unsigned CNT_W = $clog2(CoordBits);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CoordBits - 1);

  axis_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CoordBits:0]   hi_r, hi_nxt;
  logic [CoordBits-1:0] lo_r, lo_nxt;
  logic [CoordBits-1:0] mpl_r, mpl_nxt;
  logic [CoordBits-1:0] mcand_r, mcand_nxt;
  logic [CoordBits-1:0] dvs_r, dvs_nxt;
  logic [CoordBits-1:0] res_r, res_nxt;

  // The limit (extent-1) is kept aside while the multiplier shifts it away.
  logic [CoordBits-1:0] dvs_lim_r;

  logic [CoordBits:0]   mul_sum;
  logic [CoordBits:0]   rem;
  logic [CoordBits:0]   rem_sub;
  logic                 rem_ge;
  logic                 overflow;

  always_comb begin
    // Shift-add step: the upper half accumulates, its low bit moves into lo_r.
    mul_sum  = hi_r + (mpl_r[0] ? {1'b0, mcand_r} : '0);
    // Restoring division step on the partial remainder.
    rem      = {hi_r[CoordBits-1:0], lo_r[CoordBits-1]};
    rem_ge   = (rem >= {1'b0, dvs_r});
    rem_sub  = rem - {1'b0, dvs_r};
    // A quotient that needs more than CoordBits bits is certainly clamped.
    overflow = (hi_r[CoordBits-1:0] >= dvs_r);

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    mpl_nxt   = mpl_r;
    mcand_nxt = mcand_r;
    dvs_nxt   = dvs_r;
    res_nxt   = res_r;

    unique case (state_r)
      AX_IDLE: begin
        if (start) begin
          hi_nxt    = '0;
          lo_nxt    = '0;
          mpl_nxt   = ext_m1;
          mcand_nxt = value;
          dvs_nxt   = denom;
          cnt_nxt   = '0;
          state_nxt = AX_MUL;
        end
      end
      AX_MUL: begin
        hi_nxt  = {1'b0, mul_sum[CoordBits:1]};
        lo_nxt  = {mul_sum[0], lo_r[CoordBits-1:1]};
        mpl_nxt = {1'b0, mpl_r[CoordBits-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = AX_CHECK;
        end
      end
      AX_CHECK: begin
        // The multiplicand register now holds the clamp limit.
        mcand_nxt = mcand_r;
        cnt_nxt   = '0;
        if (overflow) begin
          res_nxt   = mcand_r;
          state_nxt = AX_IDLE;
        end else begin
          state_nxt = AX_DIV;
        end
      end
      AX_DIV: begin
        hi_nxt  = rem_ge ? rem_sub : rem;
        lo_nxt  = {lo_r[CoordBits-2:0], rem_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          res_nxt   = (lo_nxt > mcand_r) ? mcand_r : lo_nxt;
          state_nxt = AX_IDLE;
        end
      end
      default: begin
        state_nxt = AX_IDLE;
      end
    endcase

    // Once the product is formed the multiplicand is free to hold the limit.
    if (state_r == AX_MUL && cnt_r == LAST_STEP) begin
      mcand_nxt = dvs_lim_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AX_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    mpl_r   <= mpl_nxt;
    mcand_r <= mcand_nxt;
    dvs_r   <= dvs_nxt;
    res_r   <= res_nxt;
    if (state_r == AX_IDLE && start) begin
      dvs_lim_r <= ext_m1;
    end
  end

  assign busy   = (state_r != AX_IDLE);
  assign result = res_r;

endmodule

>>> rtl/touch_point_to_screen_mapper.sv
// Touch point to screen mapper, top level. Depends on tpsm_pkg, the channel
// interfaces in tpsm_channels_if.sv, tpsm_axis_scale and the assertion header.
//
// Every transaction on in_if carries one sampled touch report; every report
// yields exactly one transaction on out_if with the display point and a
// pressed flag. A report with a nonzero touch count is joined into raw x and
// y, optionally swapped and mirrored, then each axis is scaled in its own
// bit-serial unit: a shift-add multiply by (extent-1), an overflow check,
// and a restoring divide that an axis skips when its check finds overflow;
// a released report only repeats the held point. One report is in flight
// at a time, so the next report is taken only once the last one has been
// loaded into the output register. The output register parts the two
// sides: a new report is accepted while a finished point still waits, and a
// stalled receiver only holds the block in its final step.
// Registers are to be written on cfg_we only while the block is idle; the
// block itself does not enforce this. A synchronous reset restores the
// register defaults and clears the held point to 0,0.
`include "touch_point_to_screen_mapper_assert.svh"

module touch_point_to_screen_mapper #(
  parameter int unsigned COORD_BITS = tpsm_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tpsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]          cfg_wdata,
  tpsm_in_if.sink                        in_if,
  tpsm_out_if.source                     out_if
);
  import tpsm_pkg::*;

  // Configuration registers.
  logic [COORD_BITS-1:0] raw_max_x_r, raw_max_y_r;
  logic [COORD_BITS-1:0] screen_width_r, screen_height_r;
  logic                  swap_axes_r, invert_x_r, invert_y_r, landscape_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_max_x_r     <= '1;
      raw_max_y_r     <= '1;
      swap_axes_r     <= 1'b0;
      invert_x_r      <= 1'b0;
      invert_y_r      <= 1'b0;
      landscape_r     <= 1'b1;
      screen_width_r  <= COORD_BITS'(SCREEN_WIDTH_RST);
      screen_height_r <= COORD_BITS'(SCREEN_HEIGHT_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAW_MAX_X:     raw_max_x_r     <= cfg_wdata;
        REG_RAW_MAX_Y:     raw_max_y_r     <= cfg_wdata;
        REG_SWAP_AXES:     swap_axes_r     <= cfg_wdata[0];
        REG_INVERT_X:      invert_x_r      <= cfg_wdata[0];
        REG_INVERT_Y:      invert_y_r      <= cfg_wdata[0];
        REG_LANDSCAPE:     landscape_r     <= cfg_wdata[0];
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Mirror against the maximum; a zero maximum leaves the value alone and a
  // value beyond the maximum folds to zero.
  function automatic logic [COORD_BITS-1:0] mirror_axis(
    input logic [COORD_BITS-1:0] v,
    input logic [COORD_BITS-1:0] mx
  );
    logic [COORD_BITS-1:0] r;
    if (mx == '0) begin
      r = v;
    end else if (v <= mx) begin
      r = mx - v;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // Report preparation, straight from the input channel and the registers.
  logic [RAW_BITS-1:0]              raw_x16, raw_y16;
  logic [RAW_BITS+COORD_BITS-1:0]   raw_x_ext, raw_y_ext;
  logic [COORD_BITS-1:0]            raw_x, raw_y;
  logic [COORD_BITS-1:0]            sx, sy, mx, my, vx, vy;
  logic [COORD_BITS-1:0]            w, h, w_m1, bw, bh;
  logic [COORD_BITS-1:0]            ext_x_m1, ext_y_m1, den_x, den_y;

  always_comb begin
    raw_x16   = {in_if.x_high & NIBBLE_MASK, in_if.x_low};
    raw_y16   = {in_if.y_high & NIBBLE_MASK, in_if.y_low};
    raw_x_ext = {{COORD_BITS{1'b0}}, raw_x16};
    raw_y_ext = {{COORD_BITS{1'b0}}, raw_y16};
    raw_x     = raw_x_ext[COORD_BITS-1:0];
    raw_y     = raw_y_ext[COORD_BITS-1:0];

    sx = swap_axes_r ? raw_y : raw_x;
    sy = swap_axes_r ? raw_x : raw_y;
    mx = swap_axes_r ? raw_max_y_r : raw_max_x_r;
    my = swap_axes_r ? raw_max_x_r : raw_max_y_r;
    vx = invert_x_r ? mirror_axis(sx, mx) : sx;
    vy = invert_y_r ? mirror_axis(sy, my) : sy;

    // A zero screen size counts as one pixel.
    w    = (screen_width_r == '0) ? COORD_BITS'(1) : screen_width_r;
    h    = (screen_height_r == '0) ? COORD_BITS'(1) : screen_height_r;
    w_m1 = w - 1'b1;
    bw   = landscape_r ? w : h;
    bh   = landscape_r ? h : w;

    ext_x_m1 = bw - 1'b1;
    ext_y_m1 = bh - 1'b1;
    den_x    = (mx > COORD_BITS'(1)) ? mx - 1'b1 : COORD_BITS'(1);
    den_y    = (my > COORD_BITS'(1)) ? my - 1'b1 : COORD_BITS'(1);
  end

  // Control.
  ctrl_state_t           state_r, state_nxt;
  logic                  pressed_r;
  logic                  out_valid_r, out_pressed_r;
  logic [COORD_BITS-1:0] held_x_r, held_y_r;
  logic                  in_fire, start, load_out;
  logic                  busy_x, busy_y;
  logic [COORD_BITS-1:0] bx, by, px, py;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid & in_if.ready;
  assign start       = in_fire & (in_if.touch_count != '0);
  assign load_out    = (state_r == ST_FINISH) & (~out_valid_r | out_if.ready);

  tpsm_axis_scale #(.CoordBits(COORD_BITS)) u_scale_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .value  (vx),
    .ext_m1 (ext_x_m1),
    .denom  (den_x),
    .busy   (busy_x),
    .result (bx)
  );

  tpsm_axis_scale #(.CoordBits(COORD_BITS)) u_scale_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .value  (vy),
    .ext_m1 (ext_y_m1),
    .denom  (den_y),
    .busy   (busy_y),
    .result (by)
  );

  // Portrait rotates the scaled point into display coordinates; both results
  // already lie inside the screen, so no further clamp is needed.
  assign px = landscape_r ? bx : (w_m1 - by);
  assign py = landscape_r ? by : bx;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = start ? ST_BUSY : ST_FINISH;
        end
      end
      ST_BUSY: begin
        if (!busy_x && !busy_y) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      out_pressed_r <= 1'b0;
      pressed_r     <= 1'b0;
      held_x_r      <= '0;
      held_y_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        pressed_r <= start;
      end
      // The held point doubles as the output payload register.
      if (load_out) begin
        out_valid_r   <= 1'b1;
        out_pressed_r <= pressed_r;
        if (pressed_r) begin
          held_x_r <= px;
          held_y_r <= py;
        end
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.point_x = held_x_r;
  assign out_if.point_y = held_y_r;
  assign out_if.pressed = out_pressed_r;

  `TPSM_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_fire, !in_if.ready, "second report taken while busy")
  `TPSM_ASSERT_IMPL(a_units_idle, clk, rst_n, state_r == ST_IDLE, !busy_x && !busy_y, "axis unit busy while controller idle")
  `TPSM_ASSERT_NEXT(a_load_from_finish, clk, rst_n, state_r != ST_FINISH && !out_valid_r, !out_if.valid, "result shown without finishing")

endmodule
